FILE: rtl/hcsf_pkg.sv
package hcsf_pkg;

	// ADC and field widths
	localparam int ADC_BITS  = 12;
	localparam int SAMPLE_W  = 12;
	localparam int REG_W     = 13;
	localparam int VALUE_W   = 22;
	localparam int CFG_IDX_W = 1;

	// Datapath widths: difference, multiplier operands, product, filter sum
	localparam int DIFF_W  = REG_W + 1;
	localparam int OPA_W   = VALUE_W + 1;
	localparam int OPB_W   = REG_W + 1;
	localparam int PROD_W  = OPA_W + OPB_W;
	localparam int SUM_W   = VALUE_W + 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VREF    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_NOM = 1'd1;

	// Reset values
	localparam logic [REG_W-1:0] VREF_RST     = 13'd3300;
	localparam logic [REG_W-1:0] ZERO_NOM_RST = 13'd2500;

	// Sensing constants
	localparam int REF_WINDOW_MV = 30;
	localparam int DEAD_BAND_MV  = 10;
	localparam int MA_PER_MV     = 300;
	localparam int IDLE_CUR_MA   = -600;
	localparam int CUR_LIMIT_MA  = 1500000;
	localparam int IIR_WEIGHT    = 3;

	// Shared multiplier operations
	localparam logic [1:0] OP_MV   = 2'd0;
	localparam logic [1:0] OP_CUR  = 2'd1;
	localparam logic [1:0] OP_PREV = 2'd2;

	typedef struct packed {
		logic       en;
		logic [1:0] op;
	} alu_ctl_t;

endpackage

FILE: rtl/hcsf_alu.sv
module hcsf_alu (
	input  logic                                    clk,
	input  hcsf_pkg::alu_ctl_t                      ctl,
	input  logic [hcsf_pkg::SAMPLE_W-1:0]           sample,
	input  logic [hcsf_pkg::REG_W-1:0]              vref,
	input  logic signed [hcsf_pkg::DIFF_W-1:0]      diff,
	input  logic signed [hcsf_pkg::VALUE_W-1:0]     prev,
	output logic signed [hcsf_pkg::PROD_W-1:0]      prod_q
);
	import hcsf_pkg::*;

	logic signed [OPA_W-1:0] opa;
	logic signed [OPB_W-1:0] opb;

	// Select operands for the current step
	always_comb begin
		case (ctl.op)
			OP_MV: begin
				opa = $signed({{(OPA_W-SAMPLE_W){1'b0}}, sample});
				opb = $signed({{(OPB_W-REG_W){1'b0}}, vref});
			end
			OP_CUR: begin
				opa = OPA_W'(diff);
				opb = OPB_W'(MA_PER_MV);
			end
			OP_PREV: begin
				opa = OPA_W'(prev);
				opb = OPB_W'(IIR_WEIGHT);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= opa * opb;
		end
	end

endmodule

FILE: rtl/hall_current_sense_filter_top.sv
// Hall current sense filter.
// Input channel (in_valid/in_ready) takes one word: command and adc_sample.
// A reference word (command 0) checks the sample against the nominal zero
// within a 30 mV window, stores it or falls back to nominal, and echoes the
// sample with ref_accepted set when adopted.
// A current word (command 1) scales the sample to mV, turns the offset from
// the zero reference into mA and runs it through the 3/4 IIR. It makes
// three passes through the one shared multiplier (scale, mA gain,
// filter weight) plus operand and limit steps between them.
// in_ready is high only while the sequencer is idle; one word is in flight.
// Results leave through an output register (out_valid/out_ready). A stalled
// receiver holds the result; the block still takes the next word and parks
// it at its final step until the output register frees up.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is vref_mv, index 1 is zero_ref_nominal_mv.
// Reset: vref 3300 mV, nominal and stored zero 2500 mV, filter state 0.
module hall_current_sense_filter_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    command,
	input  logic [hcsf_pkg::SAMPLE_W-1:0]           adc_sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [hcsf_pkg::VALUE_W-1:0]     value,
	output logic                                    ref_accepted,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [hcsf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [hcsf_pkg::REG_W-1:0]              cfg_data
);
	import hcsf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REF  = 3'd1;
	localparam logic [2:0] ST_MV   = 3'd2;
	localparam logic [2:0] ST_DIFF = 3'd3;
	localparam logic [2:0] ST_CUR  = 3'd4;
	localparam logic [2:0] ST_PREV = 3'd5;
	localparam logic [2:0] ST_FILT = 3'd6;

	logic [2:0]                 state_q;
	logic [REG_W-1:0]           vref_q;
	logic [REG_W-1:0]           zero_nom_q;
	logic [REG_W-1:0]           zero_ref_q;
	logic signed [VALUE_W-1:0]  filt_q;
	logic [SAMPLE_W-1:0]        sample_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic                       dead_q;
	logic signed [VALUE_W-1:0]  raw_q;
	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  value_q;
	logic                       ref_acc_q;

	alu_ctl_t                   alu_ctl;
	logic signed [PROD_W-1:0]   prod_q;

	logic                       slot_free;
	logic                       result_done;
	logic [DIFF_W-1:0]          samp_ext;
	logic [DIFF_W-1:0]          nom_ext;
	logic                       ref_ok;
	logic [REG_W-1:0]           mv;
	logic signed [DIFF_W-1:0]   diff_next;
	logic                       dead_next;
	logic signed [PROD_W-1:0]   lim_pos;
	logic signed [PROD_W-1:0]   lim_neg;
	logic signed [VALUE_W-1:0]  raw_next;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SUM_W-1:0]    sum_adj;
	logic signed [SUM_W-1:0]    sum_q4;
	logic signed [VALUE_W-1:0]  filt_next;

	assign in_ready     = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign ref_accepted = ref_acc_q;
	assign slot_free    = !out_valid_q || out_ready;
	assign result_done  = ((state_q == ST_REF) || (state_q == ST_FILT)) && slot_free;

	// Window check on a reference sample
	assign samp_ext = DIFF_W'(sample_q);
	assign nom_ext  = DIFF_W'(zero_nom_q);
	assign ref_ok   = !((samp_ext > nom_ext + DIFF_W'(REF_WINDOW_MV)) ||
		(samp_ext + DIFF_W'(REF_WINDOW_MV) < nom_ext));

	// Millivolt offset from the stored zero and dead band
	assign mv        = prod_q[ADC_BITS+REG_W-1:ADC_BITS];
	assign diff_next = $signed(DIFF_W'(mv)) - $signed(DIFF_W'(zero_ref_q));
	assign dead_next = (diff_q >= -DIFF_W'(DEAD_BAND_MV)) &&
		(diff_q <= DIFF_W'(DEAD_BAND_MV));

	// Clamp the scaled current, or use the idle current inside the dead band
	assign lim_pos = PROD_W'(CUR_LIMIT_MA);
	assign lim_neg = -lim_pos;
	always_comb begin
		if (dead_q) begin
			raw_next = VALUE_W'(IDLE_CUR_MA);
		end else if (prod_q > lim_pos) begin
			raw_next = VALUE_W'(CUR_LIMIT_MA);
		end else if (prod_q < lim_neg) begin
			raw_next = -VALUE_W'(CUR_LIMIT_MA);
		end else begin
			raw_next = prod_q[VALUE_W-1:0];
		end
	end

	// Filter sum, divide by four toward zero
	assign sum       = prod_q[SUM_W-1:0] + SUM_W'(raw_q);
	assign sum_adj   = sum[SUM_W-1] ? sum + SUM_W'(3) : sum;
	assign sum_q4    = sum_adj >>> 2;
	assign filt_next = sum_q4[VALUE_W-1:0];

	// Drive the shared multiplier
	always_comb begin
		alu_ctl.en = 1'b0;
		alu_ctl.op = OP_MV;
		case (state_q)
			ST_MV: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = OP_MV;
			end
			ST_CUR: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = OP_CUR;
			end
			ST_PREV: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = OP_PREV;
			end
			default: begin
				alu_ctl.en = 1'b0;
				alu_ctl.op = OP_MV;
			end
		endcase
	end

	hcsf_alu u_alu (
		.clk    (clk),
		.ctl    (alu_ctl),
		.sample (sample_q),
		.vref   (vref_q),
		.diff   (diff_q),
		.prev   (filt_q),
		.prod_q (prod_q)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vref_q     <= VREF_RST;
			zero_nom_q <= ZERO_NOM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VREF:     vref_q     <= cfg_data;
				REG_ZERO_NOM: zero_nom_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequence one word and update state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zero_ref_q  <= ZERO_NOM_RST;
			filt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !result_done) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= command ? ST_MV : ST_REF;
					end
				end
				ST_REF: begin
					if (slot_free) begin
						zero_ref_q  <= ref_ok ? REG_W'(sample_q) : zero_nom_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_MV:   state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_CUR;
				ST_CUR:  state_q <= ST_PREV;
				ST_PREV: state_q <= ST_FILT;
				ST_FILT: begin
					if (slot_free) begin
						filt_q      <= filt_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_q <= adc_sample;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= diff_next;
		end
		if (state_q == ST_CUR) begin
			dead_q <= dead_next;
		end
		if (state_q == ST_PREV) begin
			raw_q <= raw_next;
		end
		if (state_q == ST_REF && slot_free) begin
			value_q   <= VALUE_W'(sample_q);
			ref_acc_q <= ref_ok;
		end
		if (state_q == ST_FILT && slot_free) begin
			value_q   <= filt_next;
			ref_acc_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/hcsf_checker.sv
module hcsf_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [hcsf_pkg::VALUE_W-1:0]     value,
	input logic                                    ref_accepted
);
	import hcsf_pkg::*;

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(ref_accepted))
		else $error("result word changed while stalled");

	// Go busy after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	// An adopted reference echoes a sample that fits the ADC range
	a_ref_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ref_accepted |-> value[VALUE_W-1:SAMPLE_W] == '0)
		else $error("adopted reference echo out of range");

	// Keep the result within the current limit
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value >= -22'sd1500000) && (value <= 22'sd1500000))
		else $error("result beyond current limit");

endmodule

bind hall_current_sense_filter_top hcsf_checker u_hcsf_checker (.*);
